[design/kmsd_pkg.sv]
// ----------------------------------------------------------------------------
// kmsd_pkg: shared definitions for the keypad matrix scanner
// Masks, phase codes, the reset value of the debounce threshold and the
// result bundle that the scan core hands to the output register.
// ----------------------------------------------------------------------------
package kmsd_pkg;

  // Sample masks
  localparam logic [7:0] ROW_MASK          = 8'hfe;
  localparam logic [7:0] SPECIAL_MASK      = 8'h71;
  localparam logic [7:0] SPECIAL_HIGH_BITS = 8'h70;

  // Phase codes: 0..7 walk columns 7..0, then the special-key phase
  localparam logic [3:0] PHASE_FIRST_COL = 4'd0;
  localparam logic [3:0] PHASE_LOW_WORD  = 4'd4;
  localparam logic [3:0] PHASE_SPECIAL   = 4'd8;

  // Debounce threshold after reset
  localparam logic [7:0] STABLE_RESET = 8'd8;
  localparam logic [7:0] RUN_MAX      = 8'hff;

  // One result beat
  typedef struct packed {
    logic [2:0]  column_select;
    logic        special_phase;
    logic        scan_done;
    logic [31:0] matrix_high;
    logic [31:0] matrix_low;
  } kmsd_result_t;

endpackage

[design/kmsd_core.sv]
// ----------------------------------------------------------------------------
// kmsd_core: debounce counter, phase walker and matrix accumulators
// Evaluates one registered sample against the scan state combinationally
// and commits the new state when the sample is advanced.
// ----------------------------------------------------------------------------
module kmsd_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            row_sample,
  input  logic [7:0]            special_sample,
  input  logic [7:0]            stable_reads_needed,
  output kmsd_pkg::kmsd_result_t result
);

  logic [3:0]  phase_r,     phase_nxt;
  logic [7:0]  prev_r,      prev_nxt;
  logic [7:0]  run_r,       run_nxt;
  logic [31:0] high_acc_r,  high_acc_nxt;
  logic [31:0] low_acc_r,   low_acc_nxt;
  logic [31:0] pub_high_r,  pub_high_nxt;
  logic [31:0] pub_low_r,   pub_low_nxt;

  logic        special;
  logic        special_nxt;
  logic        done;
  logic [7:0]  masked;
  logic [7:0]  need;
  logic [7:0]  run_count;
  logic [7:0]  key_byte;
  logic [31:0] special_bits;

  // Next-state evaluation for one sample
  always_comb begin
    special      = phase_r >= kmsd_pkg::PHASE_SPECIAL;
    masked       = special ? (special_sample & kmsd_pkg::SPECIAL_MASK)
                           : (row_sample & kmsd_pkg::ROW_MASK);
    need         = (stable_reads_needed == 8'd0) ? 8'd1 : stable_reads_needed;
    key_byte     = (~masked) & kmsd_pkg::ROW_MASK;
    // port bits 4..6 land on 28..30, port bit 0 on 31
    special_bits = {masked[0], 31'd0} |
                   {masked & kmsd_pkg::SPECIAL_HIGH_BITS, 24'd0};

    // consecutive-equal run, saturating
    if (run_r == 8'd0 || masked != prev_r) begin
      run_count = 8'd1;
    end else if (run_r < kmsd_pkg::RUN_MAX) begin
      run_count = run_r + 8'd1;
    end else begin
      run_count = run_r;
    end

    prev_nxt     = masked;
    run_nxt      = run_count;
    phase_nxt    = phase_r;
    high_acc_nxt = high_acc_r;
    low_acc_nxt  = low_acc_r;
    pub_high_nxt = pub_high_r;
    pub_low_nxt  = pub_low_r;
    done         = 1'b0;

    // phase settled
    if (run_count >= need) begin
      run_nxt = 8'd0;
      if (special) begin
        pub_high_nxt = high_acc_r | special_bits;
        pub_low_nxt  = low_acc_r;
        high_acc_nxt = 32'd0;
        low_acc_nxt  = 32'd0;
        phase_nxt    = kmsd_pkg::PHASE_FIRST_COL;
        done         = 1'b1;
      end else begin
        if (phase_r < kmsd_pkg::PHASE_LOW_WORD) begin
          high_acc_nxt = {high_acc_r[23:0], key_byte};
        end else begin
          low_acc_nxt = {low_acc_r[23:0], key_byte};
        end
        phase_nxt = phase_r + 4'd1;
      end
    end

    special_nxt          = phase_nxt >= kmsd_pkg::PHASE_SPECIAL;
    result.column_select = special_nxt ? 3'd0 : (3'd7 - phase_nxt[2:0]);
    result.special_phase = special_nxt;
    result.scan_done     = done;
    result.matrix_high   = pub_high_nxt;
    result.matrix_low    = pub_low_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= kmsd_pkg::PHASE_FIRST_COL;
      prev_r     <= 8'd0;
      run_r      <= 8'd0;
      high_acc_r <= 32'd0;
      low_acc_r  <= 32'd0;
      pub_high_r <= 32'd0;
      pub_low_r  <= 32'd0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      prev_r     <= prev_nxt;
      run_r      <= run_nxt;
      high_acc_r <= high_acc_nxt;
      low_acc_r  <= low_acc_nxt;
      pub_high_r <= pub_high_nxt;
      pub_low_r  <= pub_low_nxt;
    end
  end

  // Checks
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= kmsd_pkg::PHASE_SPECIAL)
    else $error("scan phase out of range");

  a_done_from_special: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && done) |=> (phase_r == kmsd_pkg::PHASE_FIRST_COL))
    else $error("scan did not restart after done");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_nxt != phase_r) |=> (run_r == 8'd0))
    else $error("run counter not cleared on phase change");

  a_publish_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !done) |=> $stable(pub_high_r) && $stable(pub_low_r))
    else $error("published words changed without scan done");

endmodule

[design/keypad_matrix_scan_debounce_unit.sv]
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce_unit: free-running keypad scanner with debounce
// Input sample register, scan core and result register, with one
// configuration register for the debounce threshold.
// ----------------------------------------------------------------------------
// Each accepted beat is one port sample and yields exactly one result beat.
// The block takes one sample per clock with no stalls of its own: the sample
// sits in an input register, the scan core updates its run counter, phase and
// accumulators combinationally, and the result is captured in the output
// register as the sample advances. Throughput is bounded only by out_ready.
// The threshold register is always ready and should be written while idle.
module keypad_matrix_scan_debounce_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // sample beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_row_sample,
  input  logic [7:0]  in_special_sample,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_column_select,
  output logic        out_special_phase,
  output logic        out_scan_done,
  output logic [31:0] out_matrix_high,
  output logic [31:0] out_matrix_low
);

  logic [7:0]             stable_r;
  logic                   s1_valid_r;
  logic [7:0]             s1_row_r;
  logic [7:0]             s1_special_r;
  logic                   out_valid_r;
  kmsd_pkg::kmsd_result_t out_r;
  kmsd_pkg::kmsd_result_t core_result;
  logic                   advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= kmsd_pkg::STABLE_RESET;
    end else if (cfg_valid) begin
      stable_r <= cfg_data;
    end
  end

  // Input sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_row_r     <= in_row_sample;
      s1_special_r <= in_special_sample;
    end
  end

  kmsd_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .advance             (advance),
    .row_sample          (s1_row_r),
    .special_sample      (s1_special_r),
    .stable_reads_needed (stable_r),
    .result              (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= core_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_select = out_r.column_select;
  assign out_special_phase = out_r.special_phase;
  assign out_scan_done     = out_r.scan_done;
  assign out_matrix_high   = out_r.matrix_high;
  assign out_matrix_low    = out_r.matrix_low;

endmodule
